FILE: design/rmq_pkg.sv
// rmq_pkg: widths, branch codes and the classified request type shared by the
// rotation matrix to quaternion converter; depends on nothing

package rmq_pkg;

  localparam int DATA_W = 16;
  localparam int FRAC_W = 14;
  localparam int LANES = 3;

  // exact intermediate widths
  localparam int SUM_W = DATA_W + 3;
  localparam int DIFF_W = DATA_W + 2;
  localparam int MAG_W = DATA_W + 1;
  localparam int ARG_W = DATA_W + 1;

  // square root of arg * 2^FRAC_W, two radicand bits per step
  localparam int RAD_W = ARG_W + FRAC_W;
  localparam int SQ_STEPS = (RAD_W + 1) / 2;
  localparam int ROOT_W = SQ_STEPS;
  localparam int REM_W = ROOT_W + 3;

  // divide (|d| * 2^FRAC_W + r) by 2r; 2r is at least 2^(FRAC_W/2+1)
  localparam int NUM_W = MAG_W + FRAC_W;
  localparam int DEN_W = ROOT_W + 1;
  localparam int PRE_W = FRAC_W / 2 + 1;
  localparam int Q_W = NUM_W - PRE_W;
  localparam int DREM_W = DEN_W + 1;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW = 2;

  localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    BR_W,
    BR_X,
    BR_Y,
    BR_Z
  } branch_t;

  typedef struct packed {
    branch_t                      branch;
    logic                         bad;
    logic [ARG_W-1:0]             arg;
    logic [LANES-1:0][MAG_W-1:0]  mag;
    logic [LANES-1:0]             neg;
  } rmq_item_t;

endpackage

FILE: design/rmq_front.sv
// rmq_front: accepts a matrix request, picks the branch, forms the square root
// argument and the three off-diagonal sums or differences; depends on rmq_pkg

module rmq_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                mat_valid,
  output logic                                mat_stall,
  input  logic signed [rmq_pkg::DATA_W-1:0]   m00,
  input  logic signed [rmq_pkg::DATA_W-1:0]   m01,
  input  logic signed [rmq_pkg::DATA_W-1:0]   m02,
  input  logic signed [rmq_pkg::DATA_W-1:0]   m10,
  input  logic signed [rmq_pkg::DATA_W-1:0]   m11,
  input  logic signed [rmq_pkg::DATA_W-1:0]   m12,
  input  logic signed [rmq_pkg::DATA_W-1:0]   m20,
  input  logic signed [rmq_pkg::DATA_W-1:0]   m21,
  input  logic signed [rmq_pkg::DATA_W-1:0]   m22,
  output logic                                f_valid,
  output rmq_pkg::rmq_item_t                  f_item,
  input  logic                                q_full
);
  import rmq_pkg::*;

  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_W;

  logic                      accept;
  logic signed [SUM_W-1:0]   e00, e11, e22, tr;
  logic signed [SUM_W-1:0]   arg_w, arg_x, arg_y, arg_z, arg_sel;
  logic signed [DIFF_W-1:0]  d21m12, d02m20, d10m01, s01p10, s20p02, s12p21;
  logic signed [DIFF_W-1:0]  lane_d [LANES];
  branch_t                   branch;
  rmq_item_t                 item_next;

  assign mat_stall = f_valid & q_full;
  assign accept = mat_valid & ~mat_stall;

  always_comb begin
    e00 = SUM_W'(m00);
    e11 = SUM_W'(m11);
    e22 = SUM_W'(m22);
    tr = e00 + e11 + e22;
    arg_w = tr + ONE;
    arg_x = e00 - (e11 + e22) + ONE;
    arg_y = e11 - (e22 + e00) + ONE;
    arg_z = e22 - (e00 + e11) + ONE;
    d21m12 = DIFF_W'(m21) - DIFF_W'(m12);
    d02m20 = DIFF_W'(m02) - DIFF_W'(m20);
    d10m01 = DIFF_W'(m10) - DIFF_W'(m01);
    s01p10 = DIFF_W'(m01) + DIFF_W'(m10);
    s20p02 = DIFF_W'(m20) + DIFF_W'(m02);
    s12p21 = DIFF_W'(m12) + DIFF_W'(m21);
  end

  // a nonnegative trace picks w, else the largest diagonal wins, ties go to the lower index
  always_comb begin
    if (tr >= 0) begin
      branch = BR_W;
    end else if (m00 >= m11 && m00 >= m22) begin
      branch = BR_X;
    end else if (m11 >= m22) begin
      branch = BR_Y;
    end else begin
      branch = BR_Z;
    end
  end

  always_comb begin
    case (branch)
      BR_W: begin
        arg_sel = arg_w;
        lane_d[0] = d21m12;
        lane_d[1] = d02m20;
        lane_d[2] = d10m01;
      end
      BR_X: begin
        arg_sel = arg_x;
        lane_d[0] = s01p10;
        lane_d[1] = s20p02;
        lane_d[2] = d21m12;
      end
      BR_Y: begin
        arg_sel = arg_y;
        lane_d[0] = s12p21;
        lane_d[1] = s01p10;
        lane_d[2] = d02m20;
      end
      BR_Z: begin
        arg_sel = arg_z;
        lane_d[0] = s20p02;
        lane_d[1] = s12p21;
        lane_d[2] = d10m01;
      end
      default: begin
        arg_sel = arg_w;
        lane_d[0] = d21m12;
        lane_d[1] = d02m20;
        lane_d[2] = d10m01;
      end
    endcase
  end

  always_comb begin
    item_next.branch = branch;
    item_next.bad = (arg_sel <= 0);
    item_next.arg = arg_sel[ARG_W-1:0];
    for (int l = 0; l < LANES; l++) begin
      item_next.neg[l] = lane_d[l][DIFF_W-1];
      item_next.mag[l] = lane_d[l][DIFF_W-1] ? MAG_W'(-lane_d[l]) : MAG_W'(lane_d[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= accept | (f_valid & q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= item_next;
    end
  end

endmodule

FILE: design/rmq_queue.sv
// rmq_queue: short queue of classified requests between front and back;
// depends on rmq_pkg

module rmq_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  rmq_pkg::rmq_item_t  push_item,
  output logic                full,
  output logic                q_valid,
  output rmq_pkg::rmq_item_t  q_item,
  input  logic                pop
);
  import rmq_pkg::*;

  rmq_item_t         entry [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr, rd_ptr;
  logic [Q_AW:0]     count;
  logic              do_push, do_pop;

  assign full = (count == (Q_AW+1)'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_item = entry[rd_ptr];
  assign do_push = push_valid & ~full;
  assign do_pop = pop & q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: design/rmq_back.sv
// rmq_back: pipelined square root, three pipelined dividers and the output
// register with saturation; depends on rmq_pkg

module rmq_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  rmq_pkg::rmq_item_t                 q_item,
  output logic                               pop,
  output logic                               quat_valid,
  input  logic                               quat_stall,
  output logic signed [rmq_pkg::DATA_W-1:0]  qx,
  output logic signed [rmq_pkg::DATA_W-1:0]  qy,
  output logic signed [rmq_pkg::DATA_W-1:0]  qz,
  output logic signed [rmq_pkg::DATA_W-1:0]  qw,
  output logic                               invalid
);
  import rmq_pkg::*;

  function automatic logic [DATA_W-1:0] sat_lane(input logic neg, input logic [Q_W-1:0] q);
    logic [Q_W-1:0] lim;
    logic [DATA_W-1:0] res;
    lim = Q_W'(POS_MAX) + Q_W'(neg);
    if (q > lim) begin
      res = neg ? NEG_MIN : POS_MAX;
    end else begin
      res = neg ? -DATA_W'(q) : DATA_W'(q);
    end
    return res;
  endfunction

  logic adv;

  // square root stages
  logic                    sq_v    [SQ_STEPS+1];
  rmq_item_t               sq_item [SQ_STEPS+1];
  logic [2*SQ_STEPS-1:0]   sq_rad  [SQ_STEPS+1];
  logic [REM_W-1:0]        sq_rem  [SQ_STEPS+1];
  logic [ROOT_W-1:0]       sq_root [SQ_STEPS+1];
  logic [REM_W-1:0]        sq_cur  [SQ_STEPS+1];
  logic [REM_W-1:0]        sq_try  [SQ_STEPS+1];

  // divider stages
  logic                    dv_v    [Q_W+1];
  rmq_item_t               dv_item [Q_W+1];
  logic [ROOT_W-1:0]       dv_r    [Q_W+1];
  logic [DEN_W-1:0]        dv_den  [Q_W+1];
  logic [DREM_W-1:0]       dv_rem  [Q_W+1][LANES];
  logic [Q_W-1:0]          dv_num  [Q_W+1][LANES];
  logic [Q_W-1:0]          dv_q    [Q_W+1][LANES];
  logic [DREM_W-1:0]       dv_cur  [Q_W+1][LANES];
  logic                    dv_ge   [Q_W+1][LANES];

  logic [NUM_W-1:0]        num0 [LANES];
  logic [ROOT_W:0]         r_inc;
  logic [DATA_W-1:0]       diag;
  logic [DATA_W-1:0]       c [LANES];
  logic [DATA_W-1:0]       ox, oy, oz, ow;

  assign adv = ~quat_valid | ~quat_stall;
  assign pop = adv & q_valid;

  always_comb begin
    sq_cur[0] = '0;
    sq_try[0] = '0;
    for (int s = 1; s <= SQ_STEPS; s++) begin
      sq_cur[s] = {sq_rem[s-1][REM_W-3:0], sq_rad[s-1][2*SQ_STEPS-1 -: 2]};
      sq_try[s] = REM_W'({sq_root[s-1], 2'b01});
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num0[l] = NUM_W'({sq_item[SQ_STEPS].mag[l], {FRAC_W{1'b0}}})
              + NUM_W'(sq_root[SQ_STEPS]);
      dv_cur[0][l] = '0;
      dv_ge[0][l] = 1'b0;
    end
    for (int s = 1; s <= Q_W; s++) begin
      for (int l = 0; l < LANES; l++) begin
        dv_cur[s][l] = {dv_rem[s-1][l][DREM_W-2:0], dv_num[s-1][l][Q_W-1]};
        dv_ge[s][l] = (dv_cur[s][l] >= DREM_W'(dv_den[s-1]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= SQ_STEPS; s++) begin
        sq_v[s] <= 1'b0;
      end
      for (int s = 0; s <= Q_W; s++) begin
        dv_v[s] <= 1'b0;
      end
      quat_valid <= 1'b0;
    end else if (adv) begin
      sq_v[0] <= q_valid;
      for (int s = 1; s <= SQ_STEPS; s++) begin
        sq_v[s] <= sq_v[s-1];
      end
      dv_v[0] <= sq_v[SQ_STEPS];
      for (int s = 1; s <= Q_W; s++) begin
        dv_v[s] <= dv_v[s-1];
      end
      quat_valid <= dv_v[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_item[0] <= q_item;
      sq_rad[0] <= (2*SQ_STEPS)'({q_item.arg, {FRAC_W{1'b0}}});
      sq_rem[0] <= '0;
      sq_root[0] <= '0;
      for (int s = 1; s <= SQ_STEPS; s++) begin
        sq_item[s] <= sq_item[s-1];
        sq_rad[s] <= sq_rad[s-1] << 2;
        if (sq_cur[s] >= sq_try[s]) begin
          sq_rem[s] <= sq_cur[s] - sq_try[s];
          sq_root[s] <= {sq_root[s-1][ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem[s] <= sq_cur[s];
          sq_root[s] <= {sq_root[s-1][ROOT_W-2:0], 1'b0};
        end
      end

      dv_item[0] <= sq_item[SQ_STEPS];
      dv_r[0] <= sq_root[SQ_STEPS];
      dv_den[0] <= {sq_root[SQ_STEPS], 1'b0};
      for (int l = 0; l < LANES; l++) begin
        // high numerator bits sit below the divisor, so they preload the remainder
        dv_rem[0][l] <= DREM_W'(num0[l][NUM_W-1 -: PRE_W]);
        dv_num[0][l] <= num0[l][Q_W-1:0];
        dv_q[0][l] <= '0;
      end
      for (int s = 1; s <= Q_W; s++) begin
        dv_item[s] <= dv_item[s-1];
        dv_r[s] <= dv_r[s-1];
        dv_den[s] <= dv_den[s-1];
        for (int l = 0; l < LANES; l++) begin
          dv_rem[s][l] <= dv_ge[s][l] ? dv_cur[s][l] - DREM_W'(dv_den[s-1]) : dv_cur[s][l];
          dv_num[s][l] <= dv_num[s-1][l] << 1;
          dv_q[s][l] <= {dv_q[s-1][l][Q_W-2:0], dv_ge[s][l]};
        end
      end
    end
  end

  always_comb begin
    r_inc = {1'b0, dv_r[Q_W]} + (ROOT_W+1)'(1);
    diag = DATA_W'(r_inc[ROOT_W:1]);
    for (int l = 0; l < LANES; l++) begin
      c[l] = sat_lane(dv_item[Q_W].neg[l], dv_q[Q_W][l]);
    end
    case (dv_item[Q_W].branch)
      BR_W: begin
        ox = c[0]; oy = c[1]; oz = c[2]; ow = diag;
      end
      BR_X: begin
        ox = diag; oy = c[0]; oz = c[1]; ow = c[2];
      end
      BR_Y: begin
        ox = c[1]; oy = diag; oz = c[0]; ow = c[2];
      end
      BR_Z: begin
        ox = c[0]; oy = c[1]; oz = diag; ow = c[2];
      end
      default: begin
        ox = c[0]; oy = c[1]; oz = c[2]; ow = diag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      invalid <= dv_item[Q_W].bad;
      if (dv_item[Q_W].bad) begin
        qx <= '0;
        qy <= '0;
        qz <= '0;
        qw <= '0;
      end else begin
        qx <= ox;
        qy <= oy;
        qz <= oz;
        qw <= ow;
      end
    end
  end

endmodule

FILE: design/rotation_matrix_to_quaternion.sv
// rotation_matrix_to_quaternion: top level joining front, queue and back;
// depends on rmq_pkg, rmq_front, rmq_queue, rmq_back
//
//   channel  direction  handshake              payload
//   matrix   in         mat_valid / mat_stall  m00 m01 m02 m10 m11 m12 m20 m21 m22
//   quat     out        quat_valid / quat_stall qx qy qz qw invalid
//
// one request per cycle sustained while quat_stall is low; with an empty queue
// a request passes the front register, loaded at acceptance, then the queue,
// 17 square root stages, 24 divider stages and the output register
// rst is synchronous and empties front, queue and pipeline
// quat_stall freezes the whole back pipeline while quat_valid is high; the front keeps taking requests
// until the four-entry queue and the front register are full

module rotation_matrix_to_quaternion (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               mat_valid,
  output logic                               mat_stall,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m00,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m01,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m02,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m10,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m11,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m12,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m20,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m21,
  input  logic signed [rmq_pkg::DATA_W-1:0]  m22,
  output logic                               quat_valid,
  input  logic                               quat_stall,
  output logic signed [rmq_pkg::DATA_W-1:0]  qx,
  output logic signed [rmq_pkg::DATA_W-1:0]  qy,
  output logic signed [rmq_pkg::DATA_W-1:0]  qz,
  output logic signed [rmq_pkg::DATA_W-1:0]  qw,
  output logic                               invalid
);
  import rmq_pkg::*;

  logic       f_valid, q_full, q_valid, pop;
  rmq_item_t  f_item, q_item;

  rmq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .mat_valid (mat_valid),
    .mat_stall (mat_stall),
    .m00       (m00),
    .m01       (m01),
    .m02       (m02),
    .m10       (m10),
    .m11       (m11),
    .m12       (m12),
    .m20       (m20),
    .m21       (m21),
    .m22       (m22),
    .f_valid   (f_valid),
    .f_item    (f_item),
    .q_full    (q_full)
  );

  rmq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_item  (f_item),
    .full       (q_full),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop)
  );

  rmq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .quat_valid (quat_valid),
    .quat_stall (quat_stall),
    .qx         (qx),
    .qy         (qy),
    .qz         (qz),
    .qw         (qw),
    .invalid    (invalid)
  );

endmodule

FILE: design/rmq_checker.sv
// rmq_checker: port-level checks on the converter and its bind;
// depends on rmq_pkg and rotation_matrix_to_quaternion

module rmq_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               mat_stall,
  input  logic                               quat_valid,
  input  logic                               quat_stall,
  input  logic signed [rmq_pkg::DATA_W-1:0]  qx,
  input  logic signed [rmq_pkg::DATA_W-1:0]  qy,
  input  logic signed [rmq_pkg::DATA_W-1:0]  qz,
  input  logic signed [rmq_pkg::DATA_W-1:0]  qw,
  input  logic                               invalid
);
  import rmq_pkg::*;

  localparam logic signed [DATA_W-1:0] DIAG_MIN = DATA_W'(1) << (FRAC_W / 2 - 1);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    quat_valid && quat_stall |=> quat_valid && $stable(qx) && $stable(qy)
      && $stable(qz) && $stable(qw) && $stable(invalid))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !quat_valid)
    else $error("result shown right after reset");

  a_reset_open: assert property (@(posedge clk) rst |=> !mat_stall)
    else $error("request stalled right after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    quat_valid && invalid |-> qx == 0 && qy == 0 && qz == 0 && qw == 0)
    else $error("flagged result with nonzero components");

  // the dominant component is at least half the smallest possible root
  a_dominant: assert property (@(posedge clk) disable iff (rst)
    quat_valid && !invalid |-> qx >= DIAG_MIN || qy >= DIAG_MIN || qz >= DIAG_MIN
      || qw >= DIAG_MIN)
    else $error("no dominant component in valid result");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk        (clk),
  .rst        (rst),
  .mat_stall  (mat_stall),
  .quat_valid (quat_valid),
  .quat_stall (quat_stall),
  .qx         (qx),
  .qy         (qy),
  .qz         (qz),
  .qw         (qw),
  .invalid    (invalid)
);

FILE: bench/rotation_matrix_to_quaternion_test.sv
// rotation_matrix_to_quaternion_test: self-checking bench for the matrix to quaternion
// converter; depends on rmq_pkg and rotation_matrix_to_quaternion

`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  typedef logic signed [DATA_W-1:0] elem_t;

  typedef struct {
    elem_t m [9];
  } matrix_t;

  typedef struct {
    elem_t x, y, z, w;
    logic  bad;
  } quat_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  mat_valid = 1'b0;
  logic  mat_stall;
  elem_t m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0, m12 = '0;
  elem_t m20 = '0, m21 = '0, m22 = '0;
  logic  quat_valid;
  logic  quat_stall = 1'b1;
  elem_t qx, qy, qz, qw;
  logic  invalid;

  matrix_t pending_mats[$];
  quat_t   expected_quats[$];
  int      errors = 0;
  int      sent = 0;
  int      received = 0;
  int      bad_seen = 0;
  bit      stim_done = 1'b0;
  int      hold_cycles = 0;

  rotation_matrix_to_quaternion i_dut (
    .clk, .rst, .mat_valid, .mat_stall,
    .m00, .m01, .m02, .m10, .m11, .m12, .m20, .m21, .m22,
    .quat_valid, .quat_stall, .qx, .qy, .qz, .qw, .invalid
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint isqrt(longint n);
    longint res, bt;
    res = 0;
    bt = 64'sd1 <<< 62;
    while (bt > n) bt = bt >>> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >>> 1) + bt;
      end else begin
        res = res >>> 1;
      end
      bt = bt >>> 2;
    end
    return res;
  endfunction

  function automatic longint div_by_root(longint d, longint r);
    longint mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag <<< FRAC_W) + r) / (2 * r);
    return (d < 0) ? -q : q;
  endfunction

  function automatic elem_t sat(longint v);
    longint hi;
    hi = (64'sd1 <<< (DATA_W - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return elem_t'(v);
  endfunction

  function automatic quat_t predict_quat(matrix_t a);
    longint e [9];
    longint one, tr, arg, mx, r, dg, vx, vy, vz, vw;
    branch_t br;
    quat_t q;
    for (int i = 0; i < 9; i++) e[i] = longint'(a.m[i]);
    one = 64'sd1 <<< FRAC_W;
    tr = e[0] + e[4] + e[8];
    vx = 0; vy = 0; vz = 0; vw = 0;
    if (tr >= 0) begin
      br = BR_W;
      arg = tr + one;
    end else begin
      mx = e[0];
      if (e[4] > mx) mx = e[4];
      if (e[8] > mx) mx = e[8];
      if (mx == e[0]) begin
        br = BR_X;
        arg = e[0] - (e[4] + e[8]) + one;
      end else if (mx == e[4]) begin
        br = BR_Y;
        arg = e[4] - (e[8] + e[0]) + one;
      end else begin
        br = BR_Z;
        arg = e[8] - (e[0] + e[4]) + one;
      end
    end
    q.bad = (arg <= 0);
    if (!q.bad) begin
      r = isqrt(arg <<< FRAC_W);
      dg = (r + 1) >>> 1;
      case (br)
        BR_W: begin
          vw = dg;
          vx = div_by_root(e[7] - e[5], r);
          vy = div_by_root(e[2] - e[6], r);
          vz = div_by_root(e[3] - e[1], r);
        end
        BR_X: begin
          vx = dg;
          vy = div_by_root(e[1] + e[3], r);
          vz = div_by_root(e[6] + e[2], r);
          vw = div_by_root(e[7] - e[5], r);
        end
        BR_Y: begin
          vy = dg;
          vz = div_by_root(e[5] + e[7], r);
          vx = div_by_root(e[1] + e[3], r);
          vw = div_by_root(e[2] - e[6], r);
        end
        default: begin
          vz = dg;
          vx = div_by_root(e[6] + e[2], r);
          vy = div_by_root(e[5] + e[7], r);
          vw = div_by_root(e[3] - e[1], r);
        end
      endcase
    end
    q.x = sat(vx);
    q.y = sat(vy);
    q.z = sat(vz);
    q.w = sat(vw);
    return q;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch on request %0d: %s got %0d expected %0d", received, what, got, want);
  endtask

  function automatic matrix_t make_mat(int a0, int a1, int a2, int a3, int a4,
                                       int a5, int a6, int a7, int a8);
    matrix_t t;
    t.m = '{elem_t'(a0), elem_t'(a1), elem_t'(a2), elem_t'(a3), elem_t'(a4),
            elem_t'(a5), elem_t'(a6), elem_t'(a7), elem_t'(a8)};
    return t;
  endfunction

  // random rotation-like matrix: chosen dominant axis, off-diagonal terms below 2^14 in magnitude
  function automatic matrix_t near_rotation();
    matrix_t t;
    int dom, amp;
    dom = $urandom_range(0, 3);
    amp = (1 << $urandom_range(4, 14)) - 1;
    for (int i = 0; i < 9; i++) t.m[i] = elem_t'($urandom_range(0, 2 * amp) - amp);
    for (int k = 0; k < 3; k++) begin
      if (dom == 0 || dom == k + 1) t.m[4 * k] = elem_t'($urandom_range(0, 16384));
      else t.m[4 * k] = elem_t'(-$urandom_range(0, 16384));
    end
    return t;
  endfunction

  // stall as seen at the last rising edge decides acceptance
  logic mat_stall_q = 1'b0;
  always @(posedge clk) mat_stall_q <= mat_stall;

  // driver
  int gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (mat_valid && !mat_stall_q) begin
        sent++;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
      end
      if (mat_valid && mat_stall_q) begin
        // hold payload
      end else if (gap > 0) begin
        gap--;
        mat_valid <= 1'b0;
      end else if (pending_mats.size() > 0) begin
        matrix_t t;
        t = pending_mats.pop_front();
        expected_quats.push_back(predict_quat(t));
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
          {t.m[0], t.m[1], t.m[2], t.m[3], t.m[4], t.m[5], t.m[6], t.m[7], t.m[8]};
        mat_valid <= 1'b1;
      end else begin
        mat_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random waits per result plus one long hold-off
  int wait_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      quat_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      quat_stall <= 1'b1;
    end else if (wait_left > 0) begin
      wait_left--;
      quat_stall <= 1'b1;
    end else begin
      quat_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && quat_valid && !quat_stall) begin
      quat_t q;
      received++;
      wait_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
      if (expected_quats.size() == 0) begin
        errors++;
        $display("unexpected result %0d", received);
      end else begin
        q = expected_quats.pop_front();
        if (invalid) bad_seen++;
        if (invalid !== q.bad) report_mismatch("invalid", invalid, q.bad);
        if (qx !== q.x) report_mismatch("qx", qx, q.x);
        if (qy !== q.y) report_mismatch("qy", qy, q.y);
        if (qz !== q.z) report_mismatch("qz", qz, q.z);
        if (qw !== q.w) report_mismatch("qw", qw, q.w);
      end
    end
  end

  initial begin
    matrix_t t;
    int lim;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // identity and axis half-turns (each branch), ties, extremes
    pending_mats.push_back(make_mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
    pending_mats.push_back(make_mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    pending_mats.push_back(make_mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
    pending_mats.push_back(make_mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
    pending_mats.push_back(make_mat(-100, 5, 6, 7, -100, 8, 9, 10, -100));
    pending_mats.push_back(make_mat(-9000, 1, 2, 3, -9000, 4, 5, 6, -20000));
    pending_mats.push_back(make_mat(-20000, 1, 2, 3, -9000, 4, 5, 6, -9000));
    pending_mats.push_back(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_mats.push_back(make_mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
    pending_mats.push_back(make_mat(-1, 0, 0, 0, 32767, 0, 0, 0, 32767));
    pending_mats.push_back(make_mat(32767, 32767, 32767, 32767, 32767, 32767,
                                    32767, 32767, 32767));
    pending_mats.push_back(make_mat(-32768, -32768, -32768, -32768, -32768, -32768,
                                    -32768, -32768, -32768));
    pending_mats.push_back(make_mat(-1, 32767, -32768, -32768, -32768, 32767,
                                    32767, -32768, -32768));
    pending_mats.push_back(make_mat(-32768, 32767, -32768, 32767, -32768, 32767,
                                    -32768, 32767, 32767));
    pending_mats.push_back(make_mat(0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0));
    pending_mats.push_back(make_mat(-16384, -1, -1, -1, -16385, -1, -1, -1, 16383));
    for (int n = 0; n < 1100; n++) begin
      if ($urandom_range(0, 3) == 0)
        for (int i = 0; i < 9; i++) t.m[i] = elem_t'($urandom_range(0, 65535));
      else
        t = near_rotation();
      pending_mats.push_back(t);
    end
    // long receiver hold-off while the sender keeps offering
    wait (sent > 200);
    hold_cycles = 150;
    wait (pending_mats.size() == 0 && sent > 0 && !mat_valid);
    lim = 0;
    while (expected_quats.size() > 0 && lim < 20000) begin
      @(posedge clk);
      lim++;
    end
    repeat (60) @(posedge clk);
    $display("sent %0d matrices, checked %0d quaternions, %0d flagged invalid",
             sent, received, bad_seen);
    if (errors == 0 && expected_quats.size() == 0 && received == sent)
      $display("** rotation_matrix_to_quaternion: PASSED **");
    else
      $display("** rotation_matrix_to_quaternion: FAILED **");
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("** rotation_matrix_to_quaternion: FAILED **");
    $finish;
  end

endmodule

FILE: rotation_matrix_to_quaternion.f
design/rmq_pkg.sv
design/rmq_front.sv
design/rmq_queue.sv
design/rmq_back.sv
design/rotation_matrix_to_quaternion.sv
design/rmq_checker.sv
bench/rotation_matrix_to_quaternion_test.sv
